### hdl/rgc_pkg.sv
// Shared types, constants and character decode for the readability grade counter.
`default_nettype none

package rgc_pkg;

  // Result field widths
  localparam int OUT_W   = 16;
  localparam int GRADE_W = 5;
  localparam logic [GRADE_W-1:0] GRADE_MAX = 5'd16;

  // Scaled Coleman-Liau weights (x10000 / x100)
  localparam int COEF_W = 12;
  localparam logic [COEF_W-1:0] COEF_LETTER   = 12'd588;
  localparam logic [COEF_W-1:0] COEF_SENTENCE = 12'd2960;
  localparam logic [COEF_W-1:0] COEF_WORD     = 12'd1580;
  localparam logic [COEF_W-1:0] COEF_DEN      = 12'd100;

  // ASCII codes of interest
  localparam logic [7:0] CH_UPPER_LO = 8'd65;
  localparam logic [7:0] CH_UPPER_HI = 8'd90;
  localparam logic [7:0] CH_LOWER_LO = 8'd97;
  localparam logic [7:0] CH_LOWER_HI = 8'd122;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_BANG     = 8'd33;
  localparam logic [7:0] CH_DOT      = 8'd46;
  localparam logic [7:0] CH_QUERY    = 8'd63;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_LETTER,
    CLS_SPACE,
    CLS_END
  } char_cls_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_L,
    ST_MUL_S,
    ST_MUL_W,
    ST_MUL_D,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } unit_state_t;

  // Commands from the top level to the grade unit
  typedef struct packed {
    logic start;
    logic take;
  } unit_cmd_t;

  // Status from the grade unit to the top level
  typedef struct packed {
    logic idle;
    logic done;
  } unit_sts_t;

  function automatic char_cls_t char_class(input logic [7:0] c);
    char_cls_t cls;
    cls = CLS_NONE;
    if ((c >= CH_UPPER_LO && c <= CH_UPPER_HI) || (c >= CH_LOWER_LO && c <= CH_LOWER_HI)) begin
      cls = CLS_LETTER;
    end else if (c == CH_SPACE) begin
      cls = CLS_SPACE;
    end else if (c == CH_BANG || c == CH_DOT || c == CH_QUERY) begin
      cls = CLS_END;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

### hdl/rgc_counter.sv
// Saturating letter, space and sentence counters, cleared after the final byte.
`default_nettype none

module rgc_counter #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   take,
  input  wire logic                   last,
  input  wire logic [7:0]             char_code,
  output logic      [COUNT_WIDTH-1:0] letter_upd,
  output logic      [COUNT_WIDTH-1:0] sentence_upd,
  output logic      [COUNT_WIDTH-1:0] word_upd
);

  logic [COUNT_WIDTH-1:0] letter_r, letter_nxt;
  logic [COUNT_WIDTH-1:0] space_r, space_nxt;
  logic [COUNT_WIDTH-1:0] sentence_r, sentence_nxt;
  logic [COUNT_WIDTH-1:0] space_upd;
  rgc_pkg::char_cls_t     cls;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  always_comb begin
    cls = rgc_pkg::char_class(char_code);
    letter_upd   = (cls == rgc_pkg::CLS_LETTER) ? sat_inc(letter_r) : letter_r;
    space_upd    = (cls == rgc_pkg::CLS_SPACE) ? sat_inc(space_r) : space_r;
    sentence_upd = (cls == rgc_pkg::CLS_END) ? sat_inc(sentence_r) : sentence_r;
    word_upd     = sat_inc(space_upd);
  end

  // Advance on each accepted word; drop everything after the final byte
  always_comb begin
    letter_nxt   = letter_r;
    space_nxt    = space_r;
    sentence_nxt = sentence_r;
    if (take) begin
      if (last) begin
        letter_nxt   = '0;
        space_nxt    = '0;
        sentence_nxt = '0;
      end else begin
        letter_nxt   = letter_upd;
        space_nxt    = space_upd;
        sentence_nxt = sentence_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      letter_r   <= '0;
      space_r    <= '0;
      sentence_r <= '0;
    end else begin
      letter_r   <= letter_nxt;
      space_r    <= space_nxt;
      sentence_r <= sentence_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/rgc_grade_unit.sv
// Sequenced grade unit: one shared multiplier and one shared subtractor.
`default_nettype none

module rgc_grade_unit #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rgc_pkg::unit_cmd_t            cmd,
  input  wire logic [COUNT_WIDTH-1:0]        letter_in,
  input  wire logic [COUNT_WIDTH-1:0]        sentence_in,
  input  wire logic [COUNT_WIDTH-1:0]        word_in,
  output rgc_pkg::unit_sts_t                 sts,
  output logic      [rgc_pkg::GRADE_W-1:0]   grade,
  output logic      [COUNT_WIDTH-1:0]        letter_out,
  output logic      [COUNT_WIDTH-1:0]        sentence_out,
  output logic      [COUNT_WIDTH-1:0]        word_out
);

  localparam int ACC_W = COUNT_WIDTH + 14;
  localparam int MUL_W = COUNT_WIDTH + rgc_pkg::COEF_W;

  rgc_pkg::unit_state_t state_r, state_nxt;

  logic [COUNT_WIDTH-1:0]      letter_r, sentence_r, word_r;
  logic [ACC_W-1:0]            prod_r, acc_r, rem_r, den2_r;
  logic [rgc_pkg::GRADE_W-1:0] quo_r;

  logic [COUNT_WIDTH-1:0]      mul_op;
  logic [rgc_pkg::COEF_W-1:0]  mul_coef;
  logic [MUL_W-1:0]            mul_res;
  logic [ACC_W-1:0]            alu_a, alu_b;
  logic [ACC_W:0]              alu_diff;
  logic                        num_pos;
  logic                        div_stop;

  // Control decoded from state
  logic ld_ops, acc_ld_prod, acc_ld_diff, prep, rem_ld_diff;

  // Shared multiplier: one count times one weight per cycle
  always_comb begin
    mul_op   = '0;
    mul_coef = '0;
    case (state_r)
      rgc_pkg::ST_MUL_L: begin
        mul_op   = letter_r;
        mul_coef = rgc_pkg::COEF_LETTER;
      end
      rgc_pkg::ST_MUL_S: begin
        mul_op   = sentence_r;
        mul_coef = rgc_pkg::COEF_SENTENCE;
      end
      rgc_pkg::ST_MUL_W: begin
        mul_op   = word_r;
        mul_coef = rgc_pkg::COEF_WORD;
      end
      rgc_pkg::ST_MUL_D: begin
        mul_op   = word_r;
        mul_coef = rgc_pkg::COEF_DEN;
      end
      default: begin
        mul_op   = '0;
        mul_coef = '0;
      end
    endcase
    mul_res = MUL_W'(mul_op) * MUL_W'(mul_coef);
  end

  // Shared subtractor: accumulate terms, then repeated subtract for the quotient
  always_comb begin
    if (state_r == rgc_pkg::ST_DIV) begin
      alu_a = rem_r;
      alu_b = den2_r;
    end else begin
      alu_a = acc_r;
      alu_b = prod_r;
    end
    alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
    num_pos  = !acc_r[ACC_W-1] && (acc_r != '0);
    div_stop = (quo_r == rgc_pkg::GRADE_MAX) || alu_diff[ACC_W];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rgc_pkg::ST_IDLE:  if (cmd.start) state_nxt = rgc_pkg::ST_MUL_L;
      rgc_pkg::ST_MUL_L: state_nxt = rgc_pkg::ST_MUL_S;
      rgc_pkg::ST_MUL_S: state_nxt = rgc_pkg::ST_MUL_W;
      rgc_pkg::ST_MUL_W: state_nxt = rgc_pkg::ST_MUL_D;
      rgc_pkg::ST_MUL_D: state_nxt = rgc_pkg::ST_PREP;
      rgc_pkg::ST_PREP:  state_nxt = num_pos ? rgc_pkg::ST_DIV : rgc_pkg::ST_DONE;
      rgc_pkg::ST_DIV:   if (div_stop) state_nxt = rgc_pkg::ST_DONE;
      rgc_pkg::ST_DONE:  if (cmd.take) state_nxt = rgc_pkg::ST_IDLE;
      default:           state_nxt = rgc_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    ld_ops      = 1'b0;
    acc_ld_prod = 1'b0;
    acc_ld_diff = 1'b0;
    prep        = 1'b0;
    rem_ld_diff = 1'b0;
    sts.idle    = 1'b0;
    sts.done    = 1'b0;
    unique case (state_r)
      rgc_pkg::ST_IDLE: begin
        sts.idle = 1'b1;
        ld_ops   = cmd.start;
      end
      rgc_pkg::ST_MUL_S: acc_ld_prod = 1'b1;
      rgc_pkg::ST_MUL_W: acc_ld_diff = 1'b1;
      rgc_pkg::ST_MUL_D: acc_ld_diff = 1'b1;
      rgc_pkg::ST_PREP:  prep = 1'b1;
      rgc_pkg::ST_DIV:   rem_ld_diff = !div_stop;
      rgc_pkg::ST_DONE:  sts.done = 1'b1;
      default: begin
        sts.idle = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rgc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= ACC_W'(mul_res);
    if (ld_ops) begin
      letter_r   <= letter_in;
      sentence_r <= sentence_in;
      word_r     <= word_in;
    end
    if (acc_ld_prod) begin
      acc_r <= prod_r;
    end else if (acc_ld_diff) begin
      acc_r <= alu_diff[ACC_W-1:0];
    end
    if (prep) begin
      // prod_r holds the denominator here; bias by half of it for rounding
      rem_r  <= (acc_r << 1) + prod_r;
      den2_r <= prod_r << 1;
      quo_r  <= '0;
    end else if (rem_ld_diff) begin
      rem_r <= alu_diff[ACC_W-1:0];
      quo_r <= quo_r + 1'b1;
    end
  end

  assign grade        = quo_r;
  assign letter_out   = letter_r;
  assign sentence_out = sentence_r;
  assign word_out     = word_r;

endmodule

`default_nettype wire

### hdl/readability_grade_counter.sv
// Top level of the readability grade counter: counters, grade unit, output register.
`default_nettype none

// Takes a text one ASCII byte per word on the in_ channel, with in_last_char
// marking its final byte, and counts letters, spaces and sentence end marks
// ('.', '!', '?') in saturating COUNT_WIDTH-bit counters. Ordinary bytes are
// taken one per cycle while the grade unit is idle. The final byte launches
// the grade unit, which forms 588*letters - 2960*sentences - 1580*words and
// 100*words with one shared multiplier (four products, one per cycle) and
// then finds the rounded quotient by repeated subtraction on one shared
// subtractor, clamped to 0..16. That unit sets the cost of a text's end:
// in_ready stays low from the acceptance of the final byte while the unit
// forms the products, prepares the division and runs the subtraction
// (skipped when the numerator is zero or negative, stopped at grade 16),
// and while the result waits for the output register to free up. The
// result (grade and the three totals, each cut to 16 bits) sits in an
// output register until out_ready takes it; counting of the next text may
// resume as soon as the result has moved there.

module readability_grade_counter #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_last_char,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       out_grade,
  output logic [15:0]      out_letter_total,
  output logic [15:0]      out_word_total,
  output logic [15:0]      out_sentence_total
);

  logic                   in_take;
  logic [COUNT_WIDTH-1:0] letter_upd, sentence_upd, word_upd;
  logic [COUNT_WIDTH-1:0] letter_fin, sentence_fin, word_fin;
  logic [rgc_pkg::GRADE_W-1:0] grade_fin;

  rgc_pkg::unit_cmd_t unit_cmd;
  rgc_pkg::unit_sts_t unit_sts;

  logic                          out_valid_r, out_valid_nxt;
  logic [rgc_pkg::GRADE_W-1:0]   grade_r;
  logic [rgc_pkg::OUT_W-1:0]     letter_r, word_r, sentence_r;
  logic                          out_load;

  // Take bytes whenever the grade unit is free
  assign in_ready = unit_sts.idle;
  assign in_take  = in_valid && in_ready;

  rgc_counter #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_counter (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (in_take),
    .last         (in_last_char),
    .char_code    (in_char_code),
    .letter_upd   (letter_upd),
    .sentence_upd (sentence_upd),
    .word_upd     (word_upd)
  );

  // Launch the grade on the final byte; hand back once the output register is free
  assign out_load       = unit_sts.done && (!out_valid_r || out_ready);
  assign unit_cmd.start = in_take && in_last_char;
  assign unit_cmd.take  = out_load;

  rgc_grade_unit #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_grade (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (unit_cmd),
    .letter_in    (letter_upd),
    .sentence_in  (sentence_upd),
    .word_in      (word_upd),
    .sts          (unit_sts),
    .grade        (grade_fin),
    .letter_out   (letter_fin),
    .sentence_out (sentence_fin),
    .word_out     (word_fin)
  );

  // Hold the result word until the consumer takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Cut each total to its 16-bit field; the grade used the full counts
  always_ff @(posedge clk) begin
    if (out_load) begin
      grade_r    <= grade_fin;
      letter_r   <= rgc_pkg::OUT_W'(letter_fin);
      word_r     <= rgc_pkg::OUT_W'(word_fin);
      sentence_r <= rgc_pkg::OUT_W'(sentence_fin);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_grade          = grade_r;
  assign out_letter_total   = letter_r;
  assign out_word_total     = word_r;
  assign out_sentence_total = sentence_r;

endmodule

`default_nettype wire

### tb/sv/grade_report_checker.sv
// Checker that predicts and compares the grade reports of the readability grade counter.
module grade_report_checker #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_last_char,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [4:0]  out_grade,
  input  logic [15:0] out_letter_total,
  input  logic [15:0] out_word_total,
  input  logic [15:0] out_sentence_total,
  output int          mismatch_count,
  output int          reports_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import rgc_pkg::*;

  typedef struct packed {
    logic [4:0]  grade;
    logic [15:0] letters;
    logic [15:0] words;
    logic [15:0] sentences;
  } grade_report_t;

  localparam longint COUNT_MAX   = (longint'(1) << COUNT_WIDTH) - 1;
  localparam longint W_LETTER    = 588;
  localparam longint W_SENTENCE  = 2960;
  localparam longint W_WORD      = 1580;
  localparam longint W_DEN       = 100;

  longint letters_seen;
  longint spaces_seen;
  longint ends_seen;
  grade_report_t report_q[$];

  function automatic longint sat_bump(input longint v);
    return (v >= COUNT_MAX) ? COUNT_MAX : v + 1;
  endfunction

  function automatic char_cls_t classify_byte(input logic [7:0] c);
    if ((c >= CH_UPPER_LO && c <= CH_UPPER_HI) || (c >= CH_LOWER_LO && c <= CH_LOWER_HI))
      return CLS_LETTER;
    if (c == CH_SPACE)
      return CLS_SPACE;
    if (c == CH_BANG || c == CH_DOT || c == CH_QUERY)
      return CLS_END;
    return CLS_NONE;
  endfunction

  // Round half away from zero, then clamp to 0..16.
  function automatic logic [4:0] coleman_liau_grade(input longint letters, input longint words,
                                                    input longint sentences);
    longint num;
    longint den;
    longint mag;
    longint g;
    num = W_LETTER * letters - W_SENTENCE * sentences - W_WORD * words;
    den = W_DEN * words;
    mag = (num < 0) ? -num : num;
    mag = (2 * mag + den) / (2 * den);
    g = (num < 0) ? -mag : mag;
    if (g < 1)
      return 5'd0;
    if (g >= 16)
      return GRADE_MAX;
    return g[4:0];
  endfunction

  always @(posedge clk) begin : watch
    grade_report_t got;
    grade_report_t want;
    longint words;
    if (!rst_n) begin
      letters_seen = 0;
      spaces_seen = 0;
      ends_seen = 0;
      report_q.delete();
      mismatch_count = 0;
      reports_pending = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.grade = out_grade;
        got.letters = out_letter_total;
        got.words = out_word_total;
        got.sentences = out_sentence_total;
        if (report_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected report grade=%0d letters=%0d words=%0d sentences=%0d",
                     $realtime, got.grade, got.letters, got.words, got.sentences);
        end else begin
          want = report_q.pop_front();
          if (got.grade !== want.grade || got.letters !== want.letters ||
              got.words !== want.words || got.sentences !== want.sentences) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: report mismatch exp g=%0d l=%0d w=%0d s=%0d got g=%0d l=%0d w=%0d s=%0d",
                       $realtime, want.grade, want.letters, want.words, want.sentences,
                       got.grade, got.letters, got.words, got.sentences);
          end
        end
      end
      if (in_valid && in_ready) begin
        case (classify_byte(in_char_code))
          CLS_LETTER: letters_seen = sat_bump(letters_seen);
          CLS_SPACE:  spaces_seen = sat_bump(spaces_seen);
          CLS_END:    ends_seen = sat_bump(ends_seen);
          default:    ;
        endcase
        if (in_last_char) begin
          words = sat_bump(spaces_seen);
          want.grade = coleman_liau_grade(letters_seen, words, ends_seen);
          want.letters = letters_seen[15:0];
          want.words = words[15:0];
          want.sentences = ends_seen[15:0];
          report_q.push_back(want);
          letters_seen = 0;
          spaces_seen = 0;
          ends_seen = 0;
        end
      end
      reports_pending = report_q.size();
    end
  end

endmodule

### tb/sv/testbench.sv
// Top of the readability grade counter testbench: clock, reset, text stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rgc_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int LONG_HOLD    = 500;
  localparam int DRAIN_CYCLES = 60;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic [7:0]  in_char_code;
  logic        in_last_char;
  logic        out_ready;
  wire logic   in_ready;
  wire logic   out_valid;
  wire logic [4:0]  out_grade;
  wire logic [15:0] out_letter_total;
  wire logic [15:0] out_word_total;
  wire logic [15:0] out_sentence_total;

  int mismatch_count;
  int reports_pending;

  bit gapless;         // send words back to back while set
  bit stall_request;   // ask the receiver for one long hold-off
  int rx_wait;
  int cycle_count;
  int random_bytes;
  int random_texts;
  logic [7:0] text_q[$];

  readability_grade_counter uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_char_code       (in_char_code),
    .in_last_char       (in_last_char),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_grade          (out_grade),
    .out_letter_total   (out_letter_total),
    .out_word_total     (out_word_total),
    .out_sentence_total (out_sentence_total)
  );

  grade_report_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_char_code       (in_char_code),
    .in_last_char       (in_last_char),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_grade          (out_grade),
    .out_letter_total   (out_letter_total),
    .out_word_total     (out_word_total),
    .out_sentence_total (out_sentence_total),
    .mismatch_count     (mismatch_count),
    .reports_pending    (reports_pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Abort the run if the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: after each accepted report, hold out_ready low for a random
  // wait, possibly none. A stall request drops ready for a long stretch so that a
  // report parks in the output register and the next final byte backs up.
  initial begin
    out_ready = 1'b0;
    rx_wait = 0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (stall_request) begin
          stall_request = 1'b0;
          rx_wait = LONG_HOLD;
          out_ready <= 1'b0;
        end else if (out_ready) begin
          if (out_valid) begin
            rx_wait = $urandom_range(0, 19);
            if (rx_wait > 0)
              out_ready <= 1'b0;
          end
        end else if (rx_wait > 0) begin
          rx_wait--;
          if (rx_wait == 0)
            out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Offer one word and hold it until accepted. Lower valid only when a gap
  // is drawn, so back-to-back words keep valid high across the edge.
  task send_byte(input logic [7:0] c, input logic last);
    int gap;
    gap = gapless ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= c;
    in_last_char <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task send_string(input string s);
    int i;
    for (i = 0; i < s.len(); i++)
      send_byte(s[i], i == s.len() - 1);
  endtask

  task send_text();
    int i;
    for (i = 0; i < text_q.size(); i++)
      send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  // Build prose: words of random letters, spaces between them, sentence
  // marks now and then, and a stray byte of any value sprinkled in.
  task build_prose_text();
    int n_words;
    int w;
    int k;
    int len;
    logic [7:0] letter;
    text_q.delete();
    n_words = $urandom_range(1, 6);
    for (w = 0; w < n_words; w++) begin
      len = $urandom_range(1, 12);
      for (k = 0; k < len; k++) begin
        letter = 8'($urandom_range(0, 25));
        if ($urandom_range(0, 5) == 0)
          text_q.push_back(CH_UPPER_LO + letter);
        else
          text_q.push_back(CH_LOWER_LO + letter);
        if ($urandom_range(0, 19) == 0)
          text_q.push_back(8'($urandom_range(0, 255)));
      end
      case ($urandom_range(0, 9))
        0: text_q.push_back(CH_DOT);
        1: text_q.push_back(CH_BANG);
        2: text_q.push_back(CH_QUERY);
        default: ;
      endcase
      if (w < n_words - 1)
        text_q.push_back(CH_SPACE);
    end
  endtask

  // Build a short run of arbitrary bytes.
  task build_noise_text();
    int n;
    int k;
    text_q.delete();
    n = $urandom_range(1, 8);
    for (k = 0; k < n; k++)
      text_q.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_char_code = 8'h00;
    in_last_char = 1'b0;
    gapless = 1'b0;
    stall_request = 1'b0;
    cycle_count = 0;
    random_bytes = 0;
    random_texts = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed texts: a lone letter (negative grade), the letter range edges
    // and their neighbors plus every mark, sentence marks that drive the
    // grade far below zero, bytes that count nothing (including the top
    // half of the code space), and a text that clamps at grade 16.
    send_string("A");
    send_byte(8'h60, 1'b0);
    send_string("Zz@[{ ?");
    send_string("Hi. Yo!");
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b1);
    send_string("qqqqqq");

    // Random texts, mostly prose; some go gapless. The long receiver
    // hold-off starts with the fifth text, and that text and the next are
    // sent gapless so that both end inside the hold-off and back up the input.
    while (random_bytes < 400 || random_texts < 10) begin
      if (random_texts == 4)
        stall_request = 1'b1;
      gapless = (random_texts == 4) || (random_texts == 5) ||
                ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) == 0)
        build_noise_text();
      else
        build_prose_text();
      send_text();
      random_bytes += text_q.size();
      random_texts++;
    end
    in_valid <= 1'b0;
    in_last_char <= 1'b0;

    // Drain: wait for every report, then give the block time to misbehave.
    repeat (2) @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && reports_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (reports_pending != 0)
        $display("%0d reports never arrived", reports_pending);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
